[rtl/dgas_pkg.sv]
// ----------------------------------------------------------------------------
// dgas_pkg
// Types, codes and the per-arm loop pass of the dual gripper arm sequencer.
// ----------------------------------------------------------------------------
package dgas_pkg;

   localparam logic [7:0] SERVO_DELAY_RESET = 8'd40;

   localparam logic [2:0] ADDR_SERVO_DELAY = 3'd0;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_OPEN  = 2'd1,
      CMD_GRAB  = 2'd2,
      CMD_DROP  = 2'd3
   } cmd_type;

   localparam logic [1:0] DRV_STOP = 2'd0;
   localparam logic [1:0] DRV_FWD  = 2'd1;
   localparam logic [1:0] DRV_REV  = 2'd2;

   localparam logic [1:0] FIN_CLOSED = 2'd0;
   localparam logic [1:0] FIN_OPEN   = 2'd1;
   localparam logic [1:0] FIN_PULLED = 2'd2;
   localparam logic [1:0] FIN_FOLDED = 2'd3;

   localparam logic [3:0] PH_NUM_IDLE            = 4'd0;
   localparam logic [3:0] PH_NUM_OPEN_GRAB       = 4'd1;
   localparam logic [3:0] PH_NUM_ADVANCE         = 4'd2;
   localparam logic [3:0] PH_NUM_CLOSE           = 4'd3;
   localparam logic [3:0] PH_NUM_RETRACT_LOADED  = 4'd4;
   localparam logic [3:0] PH_NUM_STOW            = 4'd5;
   localparam logic [3:0] PH_NUM_OPEN_DROP       = 4'd6;
   localparam logic [3:0] PH_NUM_PUSH            = 4'd7;
   localparam logic [3:0] PH_NUM_RETRACT_EMPTY   = 4'd8;

   typedef enum logic [8:0] {
      PH_IDLE           = 9'b000000001,
      PH_OPEN_GRAB      = 9'b000000010,
      PH_ADVANCE        = 9'b000000100,
      PH_CLOSE          = 9'b000001000,
      PH_RETRACT_LOADED = 9'b000010000,
      PH_STOW           = 9'b000100000,
      PH_OPEN_DROP      = 9'b001000000,
      PH_PUSH           = 9'b010000000,
      PH_RETRACT_EMPTY  = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic       tick;
      logic       button_low;
      logic       left_front_pin;
      logic       left_rear_pin;
      logic       right_front_pin;
      logic       right_rear_pin;
   } req_type;

   typedef struct packed {
      logic [1:0] left_drive;
      logic [1:0] right_drive;
      logic [1:0] left_finger;
      logic [1:0] right_finger;
      logic [3:0] left_phase;
      logic [3:0] right_phase;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] wait_cnt;
      logic [1:0] drive;
      logic [1:0] finger;
   } arm_type;

   function automatic logic [3:0] phase_code(input phase_type ph);
      logic [3:0] code;
      unique case (ph)
         PH_IDLE:           code = PH_NUM_IDLE;
         PH_OPEN_GRAB:      code = PH_NUM_OPEN_GRAB;
         PH_ADVANCE:        code = PH_NUM_ADVANCE;
         PH_CLOSE:          code = PH_NUM_CLOSE;
         PH_RETRACT_LOADED: code = PH_NUM_RETRACT_LOADED;
         PH_STOW:           code = PH_NUM_STOW;
         PH_OPEN_DROP:      code = PH_NUM_OPEN_DROP;
         PH_PUSH:           code = PH_NUM_PUSH;
         PH_RETRACT_EMPTY:  code = PH_NUM_RETRACT_EMPTY;
         default:           code = PH_NUM_IDLE;
      endcase
      return code;
   endfunction

   function automatic arm_type arm_pass(
      input arm_type    arm,
      input logic [1:0] command,
      input logic       tick,
      input logic       button,
      input logic       front,
      input logic       rear,
      input logic [7:0] delay
   );
      arm_type a;
      a = arm;

      unique case (cmd_type'(command))
         CMD_OPEN: begin
            a.finger   = FIN_OPEN;
            a.wait_cnt = delay;
         end
         CMD_GRAB: begin
            a.phase = PH_OPEN_GRAB;
         end
         CMD_DROP: begin
            a.finger   = FIN_OPEN;
            a.wait_cnt = delay;
            a.phase    = PH_OPEN_DROP;
         end
         default: begin
         end
      endcase

      if (tick && (a.wait_cnt != 8'd0)) begin
         a.wait_cnt = a.wait_cnt - 8'd1;
      end

      if (button) begin
         a.finger   = FIN_OPEN;
         a.wait_cnt = delay;
         a.phase    = PH_OPEN_GRAB;
      end

      unique case (a.phase)
         PH_IDLE: begin
            a.drive = rear ? DRV_FWD : DRV_STOP;
         end
         PH_OPEN_GRAB: begin
            if (a.wait_cnt == 8'd0) a.phase = PH_ADVANCE;
         end
         PH_ADVANCE: begin
            a.drive = DRV_FWD;
            if (front) begin
               a.phase    = PH_CLOSE;
               a.wait_cnt = delay;
               a.finger   = FIN_PULLED;
            end
         end
         PH_CLOSE: begin
            a.drive = front ? DRV_REV : DRV_STOP;
            if (a.wait_cnt == 8'd0) a.phase = PH_RETRACT_LOADED;
         end
         PH_RETRACT_LOADED: begin
            a.drive = DRV_REV;
            if (rear) begin
               a.drive  = DRV_STOP;
               a.phase  = PH_STOW;
               a.finger = FIN_FOLDED;
            end
         end
         PH_STOW: begin
            a.phase = PH_IDLE;
         end
         PH_OPEN_DROP: begin
            if (a.wait_cnt == 8'd0) a.phase = PH_PUSH;
         end
         PH_PUSH: begin
            a.drive = DRV_FWD;
            if (front) a.phase = PH_RETRACT_EMPTY;
         end
         PH_RETRACT_EMPTY: begin
            a.drive = DRV_REV;
            if (rear) begin
               a.phase  = PH_IDLE;
               a.finger = FIN_CLOSED;
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

endpackage

[rtl/dual_gripper_arm_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// dual_gripper_arm_sequencer_unit
// Left and right gripper arm sequencers, one control loop pass per item.
// ----------------------------------------------------------------------------
// One item is one pass of the control loop: host command, centisecond tick,
// button override, then the right and left arm state machines. The block takes
// one item per clock cycle while the result queue can take a result; an item
// passes the input register, then the arm pass into a two-entry result queue,
// and the queue keeps items flowing while the result side stalls until it fills.
// The servo delay register (byte address 0, reset 40) sets the centiseconds
// waited after fingers open or are pulled; write it only while the block is idle.
module dual_gripper_arm_sequencer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dgas_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dgas_pkg::rsp_type rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import dgas_pkg::*;

   logic [7:0] servo_delay_ff;
   logic [7:0] servo_delay_in;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;

   arm_type left_ff;
   arm_type left_in;
   arm_type right_ff;
   arm_type right_in;

   rsp_type    res_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   logic    pop;
   logic    push;
   logic    csr_write;
   rsp_type result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == ADDR_SERVO_DELAY) ? {24'd0, servo_delay_ff} : 32'd0;

   assign servo_delay_in = (csr_write && (csr_paddr == ADDR_SERVO_DELAY))
                           ? csr_pwdata[7:0] : servo_delay_ff;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = res_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign push        = in_valid_ff && ((count_ff != 2'd2) || pop);
   assign req_ready   = !in_valid_ff || push;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !push);

   always_comb begin
      right_in = right_ff;
      left_in  = left_ff;
      if (push) begin
         right_in = arm_pass(right_ff, in_item_ff.command, in_item_ff.tick,
                             !in_item_ff.button_low, !in_item_ff.right_front_pin,
                             in_item_ff.right_rear_pin, servo_delay_ff);
         left_in  = arm_pass(left_ff, in_item_ff.command, in_item_ff.tick,
                             !in_item_ff.button_low, !in_item_ff.left_front_pin,
                             in_item_ff.left_rear_pin, servo_delay_ff);
      end
   end

   always_comb begin
      result.left_drive   = left_in.drive;
      result.right_drive  = right_in.drive;
      result.left_finger  = left_in.finger;
      result.right_finger = right_in.finger;
      result.left_phase   = phase_code(left_in.phase);
      result.right_phase  = phase_code(right_in.phase);
   end

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         servo_delay_ff <= SERVO_DELAY_RESET;
         in_valid_ff    <= 1'b0;
         left_ff        <= '{phase: PH_IDLE, wait_cnt: 8'd0, drive: DRV_STOP,
                             finger: FIN_CLOSED};
         right_ff       <= '{phase: PH_IDLE, wait_cnt: 8'd0, drive: DRV_STOP,
                             finger: FIN_CLOSED};
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         count_ff       <= 2'd0;
      end else begin
         servo_delay_ff <= servo_delay_in;
         in_valid_ff    <= in_valid_in;
         left_ff        <= left_in;
         right_ff       <= right_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (push) begin
         res_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

[dv/tb_dual_gripper_arm_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tb_dual_gripper_arm_sequencer_unit
// Self-checking testbench for the dual gripper arm sequencer.
// ----------------------------------------------------------------------------
// A clocked driver sends loop-pass items from a queue with random bursts and
// gaps. On each accepted item a local model of both arm state machines
// computes the expected drives, fingers and phases. A clocked monitor stalls
// the result side on its own pattern and checks every result field by field.
// The servo delay is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module tb_dual_gripper_arm_sequencer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dgas_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [3:0] ph;
      logic [7:0] servo_cnt;
      logic [1:0] drv;
      logic [1:0] fin;
   } gripper_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   req_type     pass_q[$];
   rsp_type     expected_q[$];

   gripper_type left_arm = '0;
   gripper_type right_arm = '0;
   logic [7:0]  servo_delay = SERVO_DELAY_RESET;

   int          items_sent = 0;
   int          results_checked = 0;
   int          errors = 0;
   int          settings_used = 1;
   int          idle_cycles = 0;
   logic [15:0] phases_seen = '0;

   int          burst_cnt = 0;
   int          gap_cnt = 0;
   int          ready_cnt = 0;
   int          stall_cnt = 0;

   dual_gripper_arm_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic gripper_type loop_pass_arm(
      input gripper_type a,
      input logic [1:0]  command,
      input logic        tick,
      input logic        button,
      input logic        front,
      input logic        rear
   );
      case (cmd_type'(command))
         CMD_OPEN: begin
            a.fin = FIN_OPEN;
            a.servo_cnt = servo_delay;
         end
         CMD_GRAB: begin
            a.ph = PH_NUM_OPEN_GRAB;
         end
         CMD_DROP: begin
            a.fin = FIN_OPEN;
            a.servo_cnt = servo_delay;
            a.ph = PH_NUM_OPEN_DROP;
         end
         default: begin
         end
      endcase
      if (tick && a.servo_cnt != 8'd0) a.servo_cnt = a.servo_cnt - 8'd1;
      if (button) begin
         a.fin = FIN_OPEN;
         a.servo_cnt = servo_delay;
         a.ph = PH_NUM_OPEN_GRAB;
      end
      case (a.ph)
         PH_NUM_IDLE: a.drv = rear ? DRV_FWD : DRV_STOP;
         PH_NUM_OPEN_GRAB: begin
            if (a.servo_cnt == 8'd0) a.ph = PH_NUM_ADVANCE;
         end
         PH_NUM_ADVANCE: begin
            a.drv = DRV_FWD;
            if (front) begin
               a.ph = PH_NUM_CLOSE;
               a.servo_cnt = servo_delay;
               a.fin = FIN_PULLED;
            end
         end
         PH_NUM_CLOSE: begin
            a.drv = front ? DRV_REV : DRV_STOP;
            if (a.servo_cnt == 8'd0) a.ph = PH_NUM_RETRACT_LOADED;
         end
         PH_NUM_RETRACT_LOADED: begin
            a.drv = DRV_REV;
            if (rear) begin
               a.drv = DRV_STOP;
               a.ph = PH_NUM_STOW;
               a.fin = FIN_FOLDED;
            end
         end
         PH_NUM_STOW: a.ph = PH_NUM_IDLE;
         PH_NUM_OPEN_DROP: begin
            if (a.servo_cnt == 8'd0) a.ph = PH_NUM_PUSH;
         end
         PH_NUM_PUSH: begin
            a.drv = DRV_FWD;
            if (front) a.ph = PH_NUM_RETRACT_EMPTY;
         end
         PH_NUM_RETRACT_EMPTY: begin
            a.drv = DRV_REV;
            if (rear) begin
               a.ph = PH_NUM_IDLE;
               a.fin = FIN_CLOSED;
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   function automatic void predict_arms(input req_type r);
      rsp_type want;
      right_arm = loop_pass_arm(right_arm, r.command, r.tick, !r.button_low,
                                !r.right_front_pin, r.right_rear_pin);
      left_arm = loop_pass_arm(left_arm, r.command, r.tick, !r.button_low,
                               !r.left_front_pin, r.left_rear_pin);
      want.left_drive = left_arm.drv;
      want.right_drive = right_arm.drv;
      want.left_finger = left_arm.fin;
      want.right_finger = right_arm.fin;
      want.left_phase = left_arm.ph;
      want.right_phase = right_arm.ph;
      phases_seen[left_arm.ph] = 1'b1;
      phases_seen[right_arm.ph] = 1'b1;
      expected_q.push_back(want);
   endfunction

   function automatic req_type mk_item(
      input cmd_type    c,
      input logic       tk,
      input logic       btn,
      input logic [3:0] pins
   );
      req_type r;
      r.command = c;
      r.tick = tk;
      r.button_low = btn;
      {r.left_front_pin, r.left_rear_pin, r.right_front_pin, r.right_rear_pin} = pins;
      return r;
   endfunction

   function automatic req_type loop_item(input int tick_pct);
      req_type r;
      r.command = ($urandom_range(0, 39) == 0) ? 2'($urandom_range(0, 3)) : CMD_NONE;
      r.tick = ($urandom_range(0, 99) < tick_pct);
      r.button_low = ($urandom_range(0, 49) != 0);
      r.left_front_pin = ($urandom_range(0, 4) != 0);
      r.left_rear_pin = ($urandom_range(0, 4) == 0);
      r.right_front_pin = ($urandom_range(0, 4) != 0);
      r.right_rear_pin = ($urandom_range(0, 4) == 0);
      return r;
   endfunction

   // grab/drop/open/button or random openers followed by plain loop passes
   task automatic queue_sequences(input int target, input int dly);
      int queued;
      int len;
      int pct;
      int pick;
      logic [7:0] raw;
      req_type r;
      queued = 0;
      while (queued < target) begin
         len = $urandom_range(4 + dly, 12 + 2 * dly);
         if (len > target - queued) len = target - queued;
         pick = $urandom_range(0, 2);
         pct = (dly > 40) ? 100 : ((pick == 0) ? 50 : ((pick == 1) ? 90 : 100));
         r = loop_item(pct);
         pick = $urandom_range(0, 11);
         if (pick <= 3) r.command = CMD_GRAB;
         else if (pick <= 6) r.command = CMD_DROP;
         else if (pick == 7) r.button_low = 1'b0;
         else if (pick == 8) r.command = CMD_OPEN;
         else begin
            raw = $urandom_range(0, 255);
            r = raw;
         end
         pass_q.push_back(r);
         repeat (len) pass_q.push_back(loop_item(pct));
         queued += len + 1;
      end
   endtask

   task automatic write_servo_delay(input logic [7:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_SERVO_DELAY;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      servo_delay = value;
      settings_used++;
   endtask

   task automatic drain();
      while (pass_q.size() != 0 || req_valid || expected_q.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender: bursts of random length, random gaps
   always @(posedge clock) begin : driver
      logic nxt_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_arms(req_payload);
            items_sent++;
         end
         nxt_valid = req_valid && !req_ready;
         if (!nxt_valid) begin
            if (gap_cnt != 0) begin
               gap_cnt--;
            end else if (pass_q.size() != 0) begin
               req_payload <= pass_q.pop_front();
               nxt_valid = 1'b1;
               if (burst_cnt != 0) begin
                  burst_cnt--;
               end else begin
                  burst_cnt = $urandom_range(0, 30);
                  case ($urandom_range(0, 2))
                     0: gap_cnt = 0;
                     1: gap_cnt = $urandom_range(1, 3);
                     default: gap_cnt = $urandom_range(4, 12);
                  endcase
               end
            end
         end
         req_valid <= nxt_valid;
      end
   end

   // receiver: ready stretches and stalls of its own
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result %p", $realtime, rsp_payload);
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.left_drive !== want.left_drive ||
                   rsp_payload.right_drive !== want.right_drive ||
                   rsp_payload.left_finger !== want.left_finger ||
                   rsp_payload.right_finger !== want.right_finger ||
                   rsp_payload.left_phase !== want.left_phase ||
                   rsp_payload.right_phase !== want.right_phase) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch expected %p actual %p", $realtime,
                              want, rsp_payload);
               end
            end
         end
         if (ready_cnt != 0) begin
            ready_cnt--;
            rsp_ready <= 1'b1;
         end else if (stall_cnt != 0) begin
            stall_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            ready_cnt = $urandom_range(0, 40);
            stall_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 3);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, expected_q.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      pass_q.push_back(mk_item(CMD_NONE, 1'b0, 1'b1, 4'b1111));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b1, 4'b1010));
      pass_q.push_back(mk_item(CMD_GRAB, 1'b0, 1'b1, 4'b1010));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b1, 4'b1010));
      pass_q.push_back(mk_item(CMD_NONE, 1'b0, 1'b1, 4'b0000));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b1, 4'b0101));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b1, 4'b1010));
      pass_q.push_back(mk_item(CMD_OPEN, 1'b1, 1'b1, 4'b1010));
      pass_q.push_back(mk_item(CMD_DROP, 1'b0, 1'b1, 4'b1111));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b1, 4'b0000));
      pass_q.push_back(mk_item(CMD_NONE, 1'b1, 1'b0, 4'b0101));
      pass_q.push_back(mk_item(CMD_DROP, 1'b1, 1'b0, 4'b0000));
      pass_q.push_back(mk_item(CMD_GRAB, 1'b1, 1'b0, 4'b1111));
      pass_q.push_back(mk_item(CMD_OPEN, 1'b0, 1'b0, 4'b0000));
      pass_q.push_back(mk_item(CMD_NONE, 1'b0, 1'b1, 4'b1111));
      queue_sequences(90, SERVO_DELAY_RESET);
      drain();

      write_servo_delay(8'd0);
      queue_sequences(90, 0);
      drain();
      write_servo_delay(8'd255);
      queue_sequences(300, 255);
      drain();
      write_servo_delay(8'd3);
      queue_sequences(90, 3);
      drain();
      write_servo_delay(8'd1);
      queue_sequences(90, 1);
      drain();
      write_servo_delay(8'd8);
      queue_sequences(90, 8);
      drain();
      repeat (10) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d servo delay settings",
               items_sent, results_checked, settings_used);
      $display("arm phases reached: %b (bit n = phase n), %0d mismatches",
               phases_seen[8:0], errors);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
